### design/satc_pkg.sv
// ----------------------------------------------------------------------------
// satc_pkg
// shared types and register codes for the set-associative tag controller
// ----------------------------------------------------------------------------
package satc_pkg;

    // register indexes on the configuration port
    localparam logic [2:0] REG_REPLACE  = 3'd0;
    localparam logic [2:0] REG_WRITE    = 3'd1;
    localparam logic [2:0] REG_OFFSET   = 3'd2;
    localparam logic [2:0] REG_SET_BITS = 3'd3;
    localparam logic [2:0] REG_WAYS     = 3'd4;

    localparam int unsigned ADDR_W = 5;

    typedef struct packed {
        logic       replace_policy;
        logic       write_policy;
        logic [3:0] block_offset_bits;
        logic [3:0] set_index_bits;
        logic [3:0] ways_in_use;
    } t_cfg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SEARCH,
        ST_UPDATE
    } t_state;

endpackage

### design/satc_cfg.sv
// ----------------------------------------------------------------------------
// satc_cfg
// register bank behind the configuration port
// ----------------------------------------------------------------------------
module satc_cfg
    import satc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg r_cfg;
    logic w_wr;
    logic [2:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = paddr[ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.replace_policy    <= 1'b0;
            r_cfg.write_policy      <= 1'b0;
            r_cfg.block_offset_bits <= 4'd6;
            r_cfg.set_index_bits    <= 4'd4;
            r_cfg.ways_in_use       <= 4'd4;
        end else if (w_wr) begin
            case (w_idx)
                REG_REPLACE:  r_cfg.replace_policy    <= pwdata[0];
                REG_WRITE:    r_cfg.write_policy      <= pwdata[0];
                REG_OFFSET:   r_cfg.block_offset_bits <= pwdata[3:0];
                REG_SET_BITS: r_cfg.set_index_bits    <= pwdata[3:0];
                REG_WAYS:     r_cfg.ways_in_use       <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_REPLACE:  prdata = {31'd0, r_cfg.replace_policy};
            REG_WRITE:    prdata = {31'd0, r_cfg.write_policy};
            REG_OFFSET:   prdata = {28'd0, r_cfg.block_offset_bits};
            REG_SET_BITS: prdata = {28'd0, r_cfg.set_index_bits};
            REG_WAYS:     prdata = {28'd0, r_cfg.ways_in_use};
            default:      prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

### design/satc_store.sv
// ----------------------------------------------------------------------------
// satc_store
// per-set row memories: tags, counts, dirty bits and set fill/age
// ----------------------------------------------------------------------------
module satc_store
    import satc_pkg::*;
#(
    parameter int MAX_SETS    = 256,
    parameter int MAX_WAYS    = 8,
    parameter int COUNT_WIDTH = 32,
    parameter int SET_W       = 8,
    parameter int FILL_W      = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_rd_en,
    input  logic [SET_W-1:0]                i_rd_set,
    input  logic                            i_wr_en,
    input  logic [SET_W-1:0]                i_wr_set,
    input  logic [MAX_WAYS*32-1:0]          i_tag_row,
    input  logic [MAX_WAYS*COUNT_WIDTH-1:0] i_cnt_row,
    input  logic [MAX_WAYS-1:0]             i_dirty_row,
    input  logic [FILL_W-1:0]               i_fill,
    input  logic [COUNT_WIDTH-1:0]          i_age,
    output logic [MAX_WAYS*32-1:0]          o_tag_row,
    output logic [MAX_WAYS*COUNT_WIDTH-1:0] o_cnt_row,
    output logic [MAX_WAYS-1:0]             o_dirty_row,
    output logic [FILL_W-1:0]               o_fill,
    output logic [COUNT_WIDTH-1:0]          o_age
);

    logic [MAX_WAYS*32-1:0]          tag_mem   [MAX_SETS];
    logic [MAX_WAYS*COUNT_WIDTH-1:0] cnt_mem   [MAX_SETS];
    logic [MAX_WAYS-1:0]             dirty_mem [MAX_SETS];
    logic [FILL_W+COUNT_WIDTH-1:0]   meta_mem  [MAX_SETS];

    // one valid bit per set: an untouched set reads as empty with age zero
    logic [MAX_SETS-1:0]           r_set_vld;
    logic                          r_rd_vld;
    logic [FILL_W+COUNT_WIDTH-1:0] r_meta;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            tag_mem[i_wr_set]   <= i_tag_row;
            cnt_mem[i_wr_set]   <= i_cnt_row;
            dirty_mem[i_wr_set] <= i_dirty_row;
            meta_mem[i_wr_set]  <= {i_fill, i_age};
        end
        if (i_rd_en) begin
            o_tag_row   <= tag_mem[i_rd_set];
            o_cnt_row   <= cnt_mem[i_rd_set];
            o_dirty_row <= dirty_mem[i_rd_set];
            r_meta      <= meta_mem[i_rd_set];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (i_wr_en) r_set_vld[i_wr_set] <= 1'b1;
            if (i_rd_en) r_rd_vld <= r_set_vld[i_rd_set];
        end
    end

    assign o_fill = r_rd_vld ? r_meta[FILL_W+COUNT_WIDTH-1:COUNT_WIDTH] : '0;
    assign o_age  = r_rd_vld ? r_meta[COUNT_WIDTH-1:0] : '0;

endmodule

### design/satc_way.sv
// ----------------------------------------------------------------------------
// satc_way
// shared way compare unit: one way per step for tag match and victim choice
// ----------------------------------------------------------------------------
module satc_way
    import satc_pkg::*;
#(
    parameter int MAX_WAYS    = 8,
    parameter int COUNT_WIDTH = 32,
    parameter int WIDX_W      = 3,
    parameter int FILL_W      = 4
) (
    input  logic                            i_clk,
    input  logic                            i_step,
    input  logic [WIDX_W-1:0]               i_idx,
    input  logic [FILL_W-1:0]               i_nf,
    input  logic                            i_lfu,
    input  logic [31:0]                     i_blk,
    input  logic [MAX_WAYS*32-1:0]          i_tag_row,
    input  logic [MAX_WAYS*COUNT_WIDTH-1:0] i_cnt_row,
    output logic                            o_hit,
    output logic [WIDX_W-1:0]               o_hit_way,
    output logic [WIDX_W-1:0]               o_vic_way
);

    logic [COUNT_WIDTH-1:0] r_best;
    logic [31:0]            w_tag;
    logic [COUNT_WIDTH-1:0] w_cnt;
    logic                   w_first;
    logic                   w_match;
    logic                   w_better;

    assign w_tag    = i_tag_row[i_idx*32 +: 32];
    assign w_cnt    = i_cnt_row[i_idx*COUNT_WIDTH +: COUNT_WIDTH];
    assign w_first  = (i_idx == '0);
    assign w_match  = (FILL_W'(i_idx) < i_nf) && (w_tag == i_blk);
    // lfu: least count, lru: greatest age, earliest way on ties
    assign w_better = i_lfu ? (w_cnt < r_best) : (w_cnt > r_best);

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            if (w_first) begin
                o_hit     <= w_match;
                o_hit_way <= i_idx;
            end else if (!o_hit && w_match) begin
                o_hit     <= 1'b1;
                o_hit_way <= i_idx;
            end
            if (w_first || w_better) begin
                r_best    <= w_cnt;
                o_vic_way <= i_idx;
            end
        end
    end

endmodule

### design/set_assoc_cache_tag_controller.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_controller
// set-associative tag controller with lru or lfu replacement and totals
// ----------------------------------------------------------------------------
// flow: from input transfer to result, one row read, one step per way in the
//   shared compare unit, then one row write-back
// the input stalls until the row write-back, so only one item is in flight at a time
// reset: synchronous, clears config to defaults, totals, set valid bits
//   and the sequencer; tag and count rows are left as they are
module set_assoc_cache_tag_controller
    import satc_pkg::*;
#(
    parameter int MAX_SETS    = 256,
    parameter int MAX_WAYS    = 8,
    parameter int COUNT_WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    // input channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_command,
    input  logic [31:0]       i_address,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_hit,
    output logic              o_write_back,
    output logic [31:0]       o_read_total,
    output logic [31:0]       o_read_miss_total,
    output logic [31:0]       o_write_total,
    output logic [31:0]       o_write_miss_total,
    output logic [31:0]       o_write_back_total
);

    // floor of log2 of the set count, so a non power of two still fits
    localparam int LOG_SETS = $clog2(MAX_SETS + 1) - 1;
    localparam int SET_W    = (LOG_SETS > 0) ? LOG_SETS : 1;
    localparam int FILL_W   = $clog2(MAX_WAYS + 1);
    localparam int WIDX_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int CW       = COUNT_WIDTH;

    t_cfg   w_cfg;
    t_state r_state, n_state;

    // captured item
    logic              r_cmd;
    logic [31:0]       r_blk;
    logic [SET_W-1:0]  r_set;
    logic [WIDX_W-1:0] r_way;
    logic [WIDX_W-1:0] n_way;

    // row read data
    logic [MAX_WAYS*32-1:0] w_tag_row;
    logic [MAX_WAYS*CW-1:0] w_cnt_row;
    logic [MAX_WAYS-1:0]    w_dirty_row;
    logic [FILL_W-1:0]      w_fill;
    logic [CW-1:0]          w_age;

    // row write data
    logic [MAX_WAYS*32-1:0] n_tag_row;
    logic [MAX_WAYS*CW-1:0] n_cnt_row;
    logic [MAX_WAYS-1:0]    n_dirty_row;
    logic [FILL_W-1:0]      n_fill;
    logic [CW-1:0]          n_age;

    logic              w_hit;
    logic [WIDX_W-1:0] w_hit_way;
    logic [WIDX_W-1:0] w_vic_way;

    logic [31:0]       w_blk;
    logic [3:0]        w_bits;
    logic [SET_W-1:0]  w_set;
    logic [4:0]        w_ways5;
    logic [FILL_W-1:0] w_ways;
    logic [FILL_W-1:0] w_nf;
    logic [WIDX_W-1:0] w_last;

    logic w_accept, w_rd_en, w_step, w_finish, w_wb;

    logic        r_out_valid, r_hit, r_wb;
    logic [31:0] r_rd_tot, r_rd_miss_tot, r_wr_tot, r_wr_miss_tot, r_wb_tot;

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
        sat_inc = (v == {CW{1'b1}}) ? v : v + 1'b1;
    endfunction

    satc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // block number and set index of the incoming address
    assign w_blk  = i_address >> w_cfg.block_offset_bits;
    assign w_bits = (w_cfg.set_index_bits > 4'(LOG_SETS)) ? 4'(LOG_SETS)
                                                          : w_cfg.set_index_bits;
    assign w_set  = w_blk[SET_W-1:0] & ~({SET_W{1'b1}} << w_bits);

    // ways in use, with zero acting as one and a clamp at the maximum
    always_comb begin
        if (w_cfg.ways_in_use == 4'd0)
            w_ways5 = 5'd1;
        else if ({1'b0, w_cfg.ways_in_use} > 5'(MAX_WAYS))
            w_ways5 = 5'(MAX_WAYS);
        else
            w_ways5 = {1'b0, w_cfg.ways_in_use};
    end
    assign w_ways = FILL_W'(w_ways5);
    assign w_last = WIDX_W'(w_ways - 1'b1);
    // a set filled beyond the current way count is treated as full
    assign w_nf   = (w_fill > w_ways) ? w_ways : w_fill;

    // sequencer
    assign w_accept = i_in_valid && !o_in_stall;
    assign w_rd_en  = (r_state == ST_READ);
    assign w_step   = (r_state == ST_SEARCH);
    assign w_finish = (r_state == ST_UPDATE) && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_way   <= '0;
        end else begin
            r_state <= n_state;
            r_way   <= n_way;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_way      = r_way;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) n_state = ST_READ;
            end
            ST_READ: begin
                n_way   = '0;
                n_state = ST_SEARCH;
            end
            ST_SEARCH: begin
                if (r_way == w_last) begin
                    n_state = ST_UPDATE;
                end else begin
                    n_way = r_way + 1'b1;
                end
            end
            ST_UPDATE: begin
                if (w_finish) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_command;
            r_blk <= w_blk;
            r_set <= w_set;
        end
    end

    satc_store #(
        .MAX_SETS    (MAX_SETS),
        .MAX_WAYS    (MAX_WAYS),
        .COUNT_WIDTH (CW),
        .SET_W       (SET_W),
        .FILL_W      (FILL_W)
    ) u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (w_rd_en),
        .i_rd_set    (r_set),
        .i_wr_en     (w_finish),
        .i_wr_set    (r_set),
        .i_tag_row   (n_tag_row),
        .i_cnt_row   (n_cnt_row),
        .i_dirty_row (n_dirty_row),
        .i_fill      (n_fill),
        .i_age       (n_age),
        .o_tag_row   (w_tag_row),
        .o_cnt_row   (w_cnt_row),
        .o_dirty_row (w_dirty_row),
        .o_fill      (w_fill),
        .o_age       (w_age)
    );

    satc_way #(
        .MAX_WAYS    (MAX_WAYS),
        .COUNT_WIDTH (CW),
        .WIDX_W      (WIDX_W),
        .FILL_W      (FILL_W)
    ) u_way (
        .i_clk     (i_clk),
        .i_step    (w_step),
        .i_idx     (r_way),
        .i_nf      (w_nf),
        .i_lfu     (w_cfg.replace_policy),
        .i_blk     (r_blk),
        .i_tag_row (w_tag_row),
        .i_cnt_row (w_cnt_row),
        .o_hit     (w_hit),
        .o_hit_way (w_hit_way),
        .o_vic_way (w_vic_way)
    );

    // row update: touch on a hit, fill or replace on an allocating miss
    always_comb begin
        logic              alloc, dirty_new, lfu, wbwa, fill_mode;
        logic [WIDX_W-1:0] w;
        logic [CW-1:0]     age0, vcnt;
        n_tag_row   = w_tag_row;
        n_cnt_row   = w_cnt_row;
        n_dirty_row = w_dirty_row;
        n_fill      = w_fill;
        n_age       = w_age;
        w_wb        = 1'b0;
        lfu         = w_cfg.replace_policy;
        wbwa        = !w_cfg.write_policy;
        alloc       = !w_hit && (!r_cmd || wbwa);
        dirty_new   = r_cmd && wbwa;
        fill_mode   = (w_nf < w_ways);
        w           = fill_mode ? WIDX_W'(w_nf) : w_vic_way;
        age0        = (w_nf == '0) ? '0 : w_age;
        vcnt        = w_cnt_row[w*CW +: CW];
        if (w_hit) begin
            if (r_cmd && wbwa) n_dirty_row[w_hit_way] = 1'b1;
            if (!lfu) begin
                for (int i = 0; i < MAX_WAYS; i++) begin
                    if (FILL_W'(i) < w_ways)
                        n_cnt_row[i*CW +: CW] = sat_inc(w_cnt_row[i*CW +: CW]);
                end
                n_cnt_row[w_hit_way*CW +: CW] = '0;
            end else begin
                n_cnt_row[w_hit_way*CW +: CW] =
                    sat_inc(w_cnt_row[w_hit_way*CW +: CW]);
            end
        end else if (alloc) begin
            if (fill_mode) begin
                if (!lfu) begin
                    for (int i = 0; i < MAX_WAYS; i++) begin
                        if (WIDX_W'(i) < w && i < MAX_WAYS)
                            n_cnt_row[i*CW +: CW] = sat_inc(w_cnt_row[i*CW +: CW]);
                    end
                    n_cnt_row[w*CW +: CW] = '0;
                end else begin
                    n_age                 = age0;
                    n_cnt_row[w*CW +: CW] = sat_inc(age0);
                end
                n_fill = w_nf + 1'b1;
            end else begin
                w_wb = w_dirty_row[w];
                if (!lfu) begin
                    for (int i = 0; i < MAX_WAYS; i++) begin
                        if (FILL_W'(i) < w_ways)
                            n_cnt_row[i*CW +: CW] = (WIDX_W'(i) == w) ? '0
                                : sat_inc(w_cnt_row[i*CW +: CW]);
                    end
                end else begin
                    n_age                 = vcnt;
                    n_cnt_row[w*CW +: CW] = sat_inc(vcnt);
                end
            end
            n_tag_row[w*32 +: 32] = r_blk;
            n_dirty_row[w]        = dirty_new;
        end
    end

    // result register and running totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid   <= 1'b0;
            r_rd_tot      <= '0;
            r_rd_miss_tot <= '0;
            r_wr_tot      <= '0;
            r_wr_miss_tot <= '0;
            r_wb_tot      <= '0;
        end else if (w_finish) begin
            r_out_valid <= 1'b1;
            if (r_cmd) begin
                r_wr_tot <= r_wr_tot + 32'd1;
                if (!w_hit) r_wr_miss_tot <= r_wr_miss_tot + 32'd1;
            end else begin
                r_rd_tot <= r_rd_tot + 32'd1;
                if (!w_hit) r_rd_miss_tot <= r_rd_miss_tot + 32'd1;
            end
            if (w_wb) r_wb_tot <= r_wb_tot + 32'd1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_hit <= w_hit;
            r_wb  <= w_wb;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_hit              = r_hit;
    assign o_write_back       = r_wb;
    assign o_read_total       = r_rd_tot;
    assign o_read_miss_total  = r_rd_miss_tot;
    assign o_write_total      = r_wr_tot;
    assign o_write_miss_total = r_wr_miss_tot;
    assign o_write_back_total = r_wb_tot;

    // a result only appears after the row update
    a_out_from_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_UPDATE))
        else $error("result without row update");

    // the fill written back never exceeds the way count
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_finish |-> (n_fill <= FILL_W'(MAX_WAYS)))
        else $error("set fill beyond maximum ways");

    // the read and write totals only move when a new result is loaded
    a_totals_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(w_finish) |-> ($stable(r_rd_tot) && $stable(r_wr_tot)))
        else $error("totals changed without a result");

    // a write-back is only reported on a miss
    a_wb_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_finish && w_wb) |-> !w_hit)
        else $error("write-back on a hit");

endmodule
